// ===== design/u8251_pkg.sv =====
// Package for the 8251-subset half-duplex UART core.
// Holds command codes, status and control bit positions, and item types.
// No dependencies.
`default_nettype none

package u8251_pkg;

    typedef enum logic [2:0] {
        CMD_CONTROL = 3'd0,
        CMD_DATA_WR = 3'd1,
        CMD_STATUS_RD = 3'd2,
        CMD_DATA_RD = 3'd3,
        CMD_TICK = 3'd4
    } cmd_t;

    localparam int STATUS_W = 6;

    // status flag positions
    localparam int ST_TX_READY = 0;
    localparam int ST_RX_READY = 1;
    localparam int ST_TX_EMPTY = 2;
    localparam int ST_PAR_ERR = 3;
    localparam int ST_OVR_ERR = 4;
    localparam int ST_FRM_ERR = 5;

    localparam logic [STATUS_W-1:0] STATUS_RESET = 6'h05;

    // control byte bit positions
    localparam int CTL_TX_EN = 0;
    localparam int CTL_BREAK = 3;
    localparam int CTL_ERR_CLR = 4;
    localparam int CTL_RESET = 6;

    localparam int ATTN_BIT = 7;

    localparam logic [3:0] FRAME_BITS = 4'd11;
    localparam logic [3:0] PARITY_POS = 4'd9;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] value;
        logic attention;
        logic response_bit;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic accepted;
        logic line_valid;
        logic line_bit;
        logic line_busy;
    } result_t;

endpackage

`default_nettype wire

// ===== design/u8251_req_if.sv =====
// Request channel interface: valid/ready handshake and the input item fields.
// No dependencies.
`default_nettype none

interface u8251_req_if;
    logic valid;
    logic ready;
    logic [2:0] command;
    logic [7:0] value;
    logic attention;
    logic response_bit;

    modport source (output valid, command, value, attention, response_bit, input ready);
    modport sink (input valid, command, value, attention, response_bit, output ready);
endinterface

`default_nettype wire

// ===== design/u8251_rsp_if.sv =====
// Response channel interface: valid/ready handshake and the result item fields.
// No dependencies.
`default_nettype none

interface u8251_rsp_if;
    logic valid;
    logic ready;
    logic [7:0] read_data;
    logic accepted;
    logic line_valid;
    logic line_bit;
    logic line_busy;

    modport source (output valid, read_data, accepted, line_valid, line_bit, line_busy,
                    input ready);
    modport sink (input valid, read_data, accepted, line_valid, line_bit, line_busy,
                  output ready);
endinterface

`default_nettype wire

// ===== design/u8251_in_stage.sv =====
// Input register: captures one request item and holds it until the engine takes it.
// Depends on u8251_pkg and u8251_req_if.
`default_nettype none

module u8251_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    u8251_req_if.sink        request,
    input  logic             take,
    output logic             item_valid,
    output u8251_pkg::item_t item
);
    import u8251_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign request.ready = !valid_reg || take;
    assign valid_next = request.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            item_reg <= '{command: request.command, value: request.value,
                          attention: request.attention,
                          response_bit: request.response_bit};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// ===== design/u8251_engine.sv =====
// USART state and single-pass step logic: applies one item to the state and
// forms its result. Depends on u8251_pkg.
`default_nettype none

module u8251_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  u8251_pkg::item_t   item,
    output u8251_pkg::result_t result
);
    import u8251_pkg::*;

    logic                awaiting_mode_reg, awaiting_mode_next;
    logic                tx_en_reg, tx_en_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                break_held_reg, break_held_next;
    logic [7:0]          tx_byte_reg, tx_byte_next;
    logic [3:0]          tx_idx_reg, tx_idx_next;
    logic                sending_reg, sending_next;
    logic                listening_reg, listening_next;
    logic [3:0]          rx_idx_reg, rx_idx_next;
    logic [7:0]          rx_byte_reg, rx_byte_next;
    logic                rx_par_reg, rx_par_next;
    logic                rx_lead_reg, rx_lead_next;

    logic [3:0] tx_idx_inc;
    logic [3:0] tx_pos;
    logic [3:0] rx_pos;
    logic       tx_line;

    assign tx_idx_inc = tx_idx_reg + 4'd1;
    assign tx_pos = tx_idx_reg - 4'd1;
    assign rx_pos = rx_idx_reg - 4'd1;

    // level of the frame bit at the current transmit index
    always_comb
    begin
        if (tx_idx_reg == 4'd0)
        begin
            tx_line = 1'b0;
        end
        else if (tx_idx_reg < PARITY_POS)
        begin
            tx_line = tx_byte_reg[tx_pos[2:0]];
        end
        else if (tx_idx_reg == PARITY_POS)
        begin
            tx_line = ~^tx_byte_reg;
        end
        else
        begin
            tx_line = 1'b1;
        end
    end

    always_comb
    begin
        awaiting_mode_next = awaiting_mode_reg;
        tx_en_next = tx_en_reg;
        status_next = status_reg;
        break_held_next = break_held_reg;
        tx_byte_next = tx_byte_reg;
        tx_idx_next = tx_idx_reg;
        sending_next = sending_reg;
        listening_next = listening_reg;
        rx_idx_next = rx_idx_reg;
        rx_byte_next = rx_byte_reg;
        rx_par_next = rx_par_reg;
        rx_lead_next = rx_lead_reg;
        result = '0;

        case (cmd_t'(item.command))
            CMD_CONTROL:
            begin
                if (awaiting_mode_reg)
                begin
                    // mode byte: format is fixed, nothing to keep
                    awaiting_mode_next = 1'b0;
                end
                else if (item.value[CTL_RESET])
                begin
                    awaiting_mode_next = 1'b1;
                    tx_en_next = 1'b0;
                    status_next = STATUS_RESET;
                    break_held_next = 1'b0;
                    tx_byte_next = '0;
                    tx_idx_next = '0;
                    sending_next = 1'b0;
                    listening_next = 1'b0;
                    rx_idx_next = '0;
                    rx_byte_next = '0;
                    rx_par_next = 1'b0;
                    rx_lead_next = 1'b0;
                end
                else
                begin
                    tx_en_next = item.value[CTL_TX_EN];
                    if (item.value[CTL_ERR_CLR])
                    begin
                        status_next[ST_PAR_ERR] = 1'b0;
                        status_next[ST_OVR_ERR] = 1'b0;
                        status_next[ST_FRM_ERR] = 1'b0;
                    end
                    if (item.value[CTL_BREAK])
                    begin
                        break_held_next = 1'b1;
                    end
                    else if (break_held_reg)
                    begin
                        // break released: one mark bit
                        break_held_next = 1'b0;
                        result.line_valid = 1'b1;
                        result.line_bit = 1'b1;
                    end
                end
            end
            CMD_DATA_WR:
            begin
                if (!awaiting_mode_reg && tx_en_reg && status_reg[ST_TX_READY])
                begin
                    tx_byte_next = item.value;
                    tx_idx_next = '0;
                    sending_next = 1'b1;
                    status_next[ST_TX_READY] = 1'b0;
                    status_next[ST_TX_EMPTY] = 1'b0;
                    result.accepted = 1'b1;
                end
            end
            CMD_STATUS_RD:
            begin
                result.read_data = {2'b00, status_reg};
                result.read_data[ATTN_BIT] = !item.attention;
            end
            CMD_DATA_RD:
            begin
                result.read_data = rx_byte_reg;
                status_next[ST_RX_READY] = 1'b0;
            end
            CMD_TICK:
            begin
                if (break_held_reg)
                begin
                    result.line_valid = 1'b1;
                    result.line_bit = 1'b0;
                    result.line_busy = 1'b1;
                end
                else if (sending_reg)
                begin
                    result.line_valid = 1'b1;
                    result.line_bit = tx_line;
                    result.line_busy = 1'b1;
                    if (tx_idx_inc >= FRAME_BITS)
                    begin
                        // stop bit sent: turn the line around
                        tx_idx_next = FRAME_BITS;
                        sending_next = 1'b0;
                        listening_next = 1'b1;
                        rx_idx_next = '0;
                        rx_byte_next = '0;
                        rx_par_next = 1'b0;
                        status_next[ST_TX_READY] = 1'b1;
                        status_next[ST_TX_EMPTY] = 1'b1;
                    end
                    else
                    begin
                        tx_idx_next = tx_idx_inc;
                    end
                end
                else if (listening_reg)
                begin
                    if (rx_idx_reg == 4'd0)
                    begin
                        rx_lead_next = item.response_bit;
                    end
                    else if (rx_idx_reg < PARITY_POS)
                    begin
                        rx_byte_next[rx_pos[2:0]] = rx_byte_reg[rx_pos[2:0]]
                                                    | item.response_bit;
                        rx_par_next = rx_par_reg ^ item.response_bit;
                    end
                    else if (rx_idx_reg == PARITY_POS)
                    begin
                        rx_par_next = rx_par_reg ^ item.response_bit;
                    end

                    if (rx_idx_reg >= FRAME_BITS - 4'd1)
                    begin
                        if (rx_lead_reg || !item.response_bit)
                        begin
                            status_next[ST_FRM_ERR] = 1'b1;
                        end
                        if (!rx_par_next)
                        begin
                            status_next[ST_PAR_ERR] = 1'b1;
                        end
                        if (status_reg[ST_RX_READY])
                        begin
                            status_next[ST_OVR_ERR] = 1'b1;
                        end
                        status_next[ST_RX_READY] = 1'b1;
                        listening_next = 1'b0;
                    end
                    else
                    begin
                        rx_idx_next = rx_idx_reg + 4'd1;
                        result.line_busy = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_mode_reg <= 1'b1;
            tx_en_reg <= 1'b0;
            status_reg <= STATUS_RESET;
            break_held_reg <= 1'b0;
            tx_byte_reg <= '0;
            tx_idx_reg <= '0;
            sending_reg <= 1'b0;
            listening_reg <= 1'b0;
            rx_idx_reg <= '0;
            rx_byte_reg <= '0;
            rx_par_reg <= 1'b0;
            rx_lead_reg <= 1'b0;
        end
        else if (fire)
        begin
            awaiting_mode_reg <= awaiting_mode_next;
            tx_en_reg <= tx_en_next;
            status_reg <= status_next;
            break_held_reg <= break_held_next;
            tx_byte_reg <= tx_byte_next;
            tx_idx_reg <= tx_idx_next;
            sending_reg <= sending_next;
            listening_reg <= listening_next;
            rx_idx_reg <= rx_idx_next;
            rx_byte_reg <= rx_byte_next;
            rx_par_reg <= rx_par_next;
            rx_lead_reg <= rx_lead_next;
        end
    end

`ifndef SYNTHESIS
    a_tx_ready_tracks_send: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[ST_TX_READY] == !sending_reg
        && status_reg[ST_TX_EMPTY] == !sending_reg)
        else $error("tx ready/empty out of step with sending");

    a_tx_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> tx_idx_reg < FRAME_BITS)
        else $error("transmit index past frame while sending");

    a_rx_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        listening_reg |-> rx_idx_reg < FRAME_BITS)
        else $error("receive index past frame");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(status_reg) && $stable(sending_reg) && $stable(listening_reg))
        else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// ===== design/u8251_out_stage.sv =====
// Result register: holds one result item until the response side takes it.
// Depends on u8251_pkg and u8251_rsp_if.
`default_nettype none

module u8251_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    u8251_rsp_if.source        response,
    input  logic               load,
    input  u8251_pkg::result_t result,
    output logic               room
);
    import u8251_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign room = !valid_reg || response.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign response.valid = valid_reg;
    assign response.read_data = result_reg.read_data;
    assign response.accepted = result_reg.accepted;
    assign response.line_valid = result_reg.line_valid;
    assign response.line_bit = result_reg.line_bit;
    assign response.line_busy = result_reg.line_busy;

endmodule

`default_nettype wire

// ===== design/uart_8251_subset_half_duplex_core.sv =====
// Top level of the 8251-subset half-duplex UART (8 data bits, odd parity, 1 stop).
// Depends on u8251_pkg, u8251_req_if, u8251_rsp_if and the stage modules.
//
//  channel    dir   handshake     payload
//  request    in    valid/ready   command, value, attention, response_bit
//  response   out   valid/ready   read_data, accepted, line_valid, line_bit, line_busy
//
// One item per cycle sustained while the response is not stalled; a request item is
// registered in the input register, then its result goes through the step logic into the result register.
// The state update for an item happens in the cycle it moves into the result register.
// A stalled response holds its result and the item behind it; the request side
// keeps taking items while the input register is free.
// Reset: control and engine state asynchronous to power-on values; item and result data are not reset.
`default_nettype none

module uart_8251_subset_half_duplex_core (
    input  logic      clk,
    input  logic      rst_n,
    u8251_req_if.sink request,
    u8251_rsp_if.source response
);
    import u8251_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    room;
    logic    fire;

    assign fire = item_valid && room;

    u8251_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    u8251_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    u8251_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .response (response),
        .load     (fire),
        .result   (result),
        .room     (room)
    );

endmodule

`default_nettype wire
